// ===== rtl/ppd_pkg.sv =====
//------------------------------------------------------------------------------
// ppd_pkg
// Shared widths, types and register codes of the periodic pair distance block.
//------------------------------------------------------------------------------
package ppd_pkg;

    localparam int COORD_INT_BITS  = 12;
    localparam int COORD_FRAC_BITS = 8;
    localparam int COORD_W         = COORD_INT_BITS + COORD_FRAC_BITS;

    localparam int BOX_W = 12;
    localparam logic [BOX_W-1:0] BOX_RESET = 12'd4095;

    // folded differences must hold a whole box in coordinate units
    localparam int D_W    = (COORD_W > BOX_W + COORD_FRAC_BITS) ?
                            COORD_W : BOX_W + COORD_FRAC_BITS;
    localparam int SQ_W   = 2 * D_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = D_W + 1;
    localparam int DIST_W = COORD_W + 1;

    // diff, fold, square, sum, then one stage per root bit
    localparam int PIPE_STAGES = 4 + ROOT_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BOX_W;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 1'b1;

    typedef logic [COORD_W-1:0]    t_coord;
    typedef logic [BOX_W-1:0]      t_box;
    typedef logic [D_W-1:0]        t_diff;
    typedef logic [SQ_W-1:0]       t_sq;
    typedef logic [SUM_W-1:0]      t_sum;
    typedef logic [ROOT_W-1:0]     t_root;
    typedef logic [DIST_W-1:0]     t_dist;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    typedef struct packed {
        t_box x;
        t_box z;
    } t_box_cfg;

endpackage

// ===== rtl/ppd_if.sv =====
//------------------------------------------------------------------------------
// ppd channel interfaces
// Valid/ready channels for particle pairs, distances and register writes.
//------------------------------------------------------------------------------
interface ppd_pair_if;
    import ppd_pkg::*;

    logic   valid;
    logic   ready;
    t_coord first_x;
    t_coord first_y;
    t_coord first_z;
    t_coord second_x;
    t_coord second_y;
    t_coord second_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
        output ready
    );
endinterface

interface ppd_dist_if;
    import ppd_pkg::*;

    logic  valid;
    logic  ready;
    t_dist distance;

    modport source (output valid, distance, input ready);
    modport sink (input valid, distance, output ready);
endinterface

interface ppd_cfg_if;
    import ppd_pkg::*;

    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ppd_diff_fold.sv =====
//------------------------------------------------------------------------------
// ppd_diff_fold
// Two stages: absolute axis differences, then minimum-image fold on x and z.
//------------------------------------------------------------------------------
module ppd_diff_fold (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  ppd_pkg::t_coord   i_first_x,
    input  ppd_pkg::t_coord   i_first_y,
    input  ppd_pkg::t_coord   i_first_z,
    input  ppd_pkg::t_coord   i_second_x,
    input  ppd_pkg::t_coord   i_second_y,
    input  ppd_pkg::t_coord   i_second_z,
    input  ppd_pkg::t_box_cfg i_box,
    output logic              o_vld,
    output ppd_pkg::t_diff    o_dx,
    output ppd_pkg::t_diff    o_dy,
    output ppd_pkg::t_diff    o_dz
);
    import ppd_pkg::*;

    function automatic t_diff abs_diff(input t_diff a, input t_diff b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // strict compare against half a box, then reflect against the full box
    function automatic t_diff fold(input t_diff d, input t_box box);
        t_diff half;
        t_diff full;
        half = t_diff'(box[BOX_W-1:1]) << COORD_FRAC_BITS;
        full = t_diff'(box) << COORD_FRAC_BITS;
        return (d > half) ? abs_diff(full, d) : d;
    endfunction

    logic  r_vld_d;
    t_diff r_dx_raw;
    t_diff r_dy_raw;
    t_diff r_dz_raw;
    logic  r_vld_f;
    t_diff r_dx;
    t_diff r_dy;
    t_diff r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= 1'b0;
            r_vld_f <= 1'b0;
        end else if (i_en) begin
            r_vld_d <= i_vld;
            r_vld_f <= r_vld_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx_raw <= abs_diff(t_diff'(i_first_x), t_diff'(i_second_x));
            r_dy_raw <= abs_diff(t_diff'(i_first_y), t_diff'(i_second_y));
            r_dz_raw <= abs_diff(t_diff'(i_first_z), t_diff'(i_second_z));
            r_dx     <= fold(r_dx_raw, i_box.x);
            r_dy     <= r_dy_raw;
            r_dz     <= fold(r_dz_raw, i_box.z);
        end
    end

    assign o_vld = r_vld_f;
    assign o_dx  = r_dx;
    assign o_dy  = r_dy;
    assign o_dz  = r_dz;

endmodule

// ===== rtl/ppd_sq_sum.sv =====
//------------------------------------------------------------------------------
// ppd_sq_sum
// Two stages: three registered squares, then their exact sum.
//------------------------------------------------------------------------------
module ppd_sq_sum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  ppd_pkg::t_diff i_dx,
    input  ppd_pkg::t_diff i_dy,
    input  ppd_pkg::t_diff i_dz,
    output logic           o_vld,
    output ppd_pkg::t_sum  o_sum
);
    import ppd_pkg::*;

    logic r_vld_sq;
    t_sq  r_sq_x;
    t_sq  r_sq_y;
    t_sq  r_sq_z;
    logic r_vld_sum;
    t_sum r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sq  <= 1'b0;
            r_vld_sum <= 1'b0;
        end else if (i_en) begin
            r_vld_sq  <= i_vld;
            r_vld_sum <= r_vld_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_x <= t_sq'(i_dx) * t_sq'(i_dx);
            r_sq_y <= t_sq'(i_dy) * t_sq'(i_dy);
            r_sq_z <= t_sq'(i_dz) * t_sq'(i_dz);
            r_sum  <= t_sum'(r_sq_x) + t_sum'(r_sq_y) + t_sum'(r_sq_z);
        end
    end

    assign o_vld = r_vld_sum;
    assign o_sum = r_sum;

endmodule

// ===== rtl/ppd_sqrt.sv =====
//------------------------------------------------------------------------------
// ppd_sqrt
// Pipelined restoring floor square root, one root bit per stage.
//------------------------------------------------------------------------------
module ppd_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  ppd_pkg::t_sum  i_sum,
    output logic           o_vld,
    output ppd_pkg::t_root o_root
);
    import ppd_pkg::*;

    logic  r_vld  [ROOT_W];
    t_sum  r_rem  [ROOT_W];
    t_root r_root [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - g;

        logic  src_vld;
        t_sum  src_rem;
        t_root src_root;
        t_sum  trial;

        if (g == 0) begin : g_first
            assign src_vld  = i_vld;
            assign src_rem  = i_sum;
            assign src_root = '0;
        end else begin : g_next
            assign src_vld  = r_vld[g-1];
            assign src_rem  = r_rem[g-1];
            assign src_root = r_root[g-1];
        end

        // (4q + 1) * 4^bit is what setting this root bit adds to the square
        assign trial = t_sum'({src_root, 2'b01}) << (2 * BIT);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (src_rem >= trial) begin
                    r_rem[g]  <= src_rem - trial;
                    r_root[g] <= {src_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[g]  <= src_rem;
                    r_root[g] <= {src_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];

endmodule

// ===== rtl/ppd_out_skid.sv =====
//------------------------------------------------------------------------------
// ppd_out_skid
// Output register plus skid entry; holds the pipeline only when both are full.
//------------------------------------------------------------------------------
module ppd_out_skid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  ppd_pkg::t_root i_root,
    output logic           o_pipe_en,
    ppd_dist_if.source     o_dist
);
    import ppd_pkg::*;

    logic  r_out_vld;
    t_dist r_out;
    logic  r_skid_vld;
    t_dist r_skid;
    logic  take;
    logic  up_move;
    t_dist up_dist;

    assign o_pipe_en = !r_skid_vld;
    assign take      = !r_out_vld || o_dist.ready;
    assign up_move   = i_vld && !r_skid_vld;
    assign up_dist   = i_root[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (take) begin
            r_out_vld  <= r_skid_vld || up_move;
            r_skid_vld <= 1'b0;
        end else if (up_move) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_vld ? r_skid : up_dist;
        end else if (up_move) begin
            r_skid <= up_dist;
        end
    end

    assign o_dist.valid    = r_out_vld;
    assign o_dist.distance = r_out;

endmodule

// ===== rtl/periodic_pair_distance.sv =====
//------------------------------------------------------------------------------
// periodic_pair_distance
// Minimum-image distance of two particles, x and z periodic, y bounded.
//------------------------------------------------------------------------------
// The block accepts one pair item per clock while i_pair.ready is high and
// returns one distance item per pair, in order. Each pair passes through two
// stages for difference and fold, one for the squares, one for their sum, one
// per root bit in the square root (21 at Q12.8), and the output register. A
// stalled output first fills a one-entry skid stage; only then does
// i_pair.ready drop. Box sizes are written through i_cfg at any time and reset
// to 4095; they must not change while items are in flight.
module periodic_pair_distance (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppd_pair_if.sink   i_pair,
    ppd_cfg_if.sink    i_cfg,
    ppd_dist_if.source o_dist
);
    import ppd_pkg::*;

    t_box_cfg r_box;
    logic     pipe_en;
    logic     in_vld;
    logic     fold_vld;
    t_diff    fold_dx;
    t_diff    fold_dy;
    t_diff    fold_dz;
    logic     sum_vld;
    t_sum     sum;
    logic     root_vld;
    t_root    root;

    assign i_cfg.ready  = 1'b1;
    assign i_pair.ready = pipe_en;
    assign in_vld       = i_pair.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.x <= BOX_RESET;
            r_box.z <= BOX_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BOX_X: r_box.x <= i_cfg.data;
                CFG_BOX_Z: r_box.z <= i_cfg.data;
                default: ;
            endcase
        end
    end

    ppd_diff_fold u_diff_fold (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_vld      (in_vld),
        .i_first_x  (i_pair.first_x),
        .i_first_y  (i_pair.first_y),
        .i_first_z  (i_pair.first_z),
        .i_second_x (i_pair.second_x),
        .i_second_y (i_pair.second_y),
        .i_second_z (i_pair.second_z),
        .i_box      (r_box),
        .o_vld      (fold_vld),
        .o_dx       (fold_dx),
        .o_dy       (fold_dy),
        .o_dz       (fold_dz)
    );

    ppd_sq_sum u_sq_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (fold_vld),
        .i_dx    (fold_dx),
        .i_dy    (fold_dy),
        .i_dz    (fold_dz),
        .o_vld   (sum_vld),
        .o_sum   (sum)
    );

    ppd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (sum_vld),
        .i_sum   (sum),
        .o_vld   (root_vld),
        .o_root  (root)
    );

    ppd_out_skid u_out_skid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (root_vld),
        .i_root    (root),
        .o_pipe_en (pipe_en),
        .o_dist    (o_dist)
    );

endmodule

// ===== rtl/ppd_checker.sv =====
//------------------------------------------------------------------------------
// ppd_checker
// Port-level checks on stalled outputs, item counts, occupancy and register writes, bound to the top level.
//------------------------------------------------------------------------------
module ppd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input ppd_pkg::t_dist i_out_distance,
    input logic           i_cfg_ready
);
    import ppd_pkg::*;

    // pipeline stages, output register and skid entry
    localparam int MAX_INFLIGHT = PIPE_STAGES + 2;
    localparam int CNT_W        = $clog2(MAX_INFLIGHT + 2);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             in_fire;
    logic             out_fire;

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (in_fire && !out_fire) begin
            n_cnt = r_cnt + 1'b1;
        end else if (out_fire && !in_fire) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_distance))
        else $error("distance item changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("distance item without an outstanding pair item");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_INFLIGHT))
        else $error("more items in flight than the pipeline holds");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register write not taken");

endmodule

bind periodic_pair_distance ppd_checker u_ppd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_pair.valid),
    .i_in_ready     (i_pair.ready),
    .i_out_valid    (o_dist.valid),
    .i_out_ready    (o_dist.ready),
    .i_out_distance (o_dist.distance),
    .i_cfg_ready    (i_cfg.ready)
);
